[hdl/char_cell_sprite_compositor_assert.svh]
// Assertion macros shared by the checker of the frame store compositor.
`ifndef CHAR_CELL_SPRITE_COMPOSITOR_ASSERT_SVH
`define CHAR_CELL_SPRITE_COMPOSITOR_ASSERT_SVH

// Check a condition in the same cycle as its trigger.
`define CCSC_ASSERT_NOW(lbl, clk, dis, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) else $error(msg);

// Check a condition in the cycle after its trigger.
`define CCSC_ASSERT_NEXT(lbl, clk, dis, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) else $error(msg);

`endif

[hdl/ccsc_pkg.sv]
// Shared types and constants of the character-cell sprite compositor.
package ccsc_pkg;

  localparam int FRAME_WIDTH  = 40;
  localparam int FRAME_HEIGHT = 20;
  localparam int CELL_COUNT   = FRAME_WIDTH * FRAME_HEIGHT;

  localparam int ADDR_W = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;
  localparam int COL_W  = (FRAME_WIDTH > 1) ? $clog2(FRAME_WIDTH) : 1;
  localparam int ROW_W  = (FRAME_HEIGHT > 1) ? $clog2(FRAME_HEIGHT) : 1;

  localparam int CODE_W = 16;

  // Command queue and result queue; depths are powers of two so pointers wrap.
  localparam int Q_DEPTH     = 4;
  localparam int Q_PTR_W     = $clog2(Q_DEPTH);
  localparam int Q_CNT_W     = $clog2(Q_DEPTH + 1);
  localparam int OUT_DEPTH   = 4;
  localparam int OUT_PTR_W   = $clog2(OUT_DEPTH);
  localparam int OUT_CNT_W   = $clog2(OUT_DEPTH + 1);

  localparam logic [7:0] SPACE_BYTE = 8'h20;
  localparam logic [CODE_W-1:0] KEY_RESET = 16'hA1A1;

  // Configuration register map
  localparam int PADDR_W = 3;
  localparam logic [0:0] REG_KEY = 1'b0;

  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_PLOT  = 2'd1,
    CMD_EMIT  = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_PLOT  = 2'd1,
    OP_EMIT  = 2'd2
  } op_kind_t;

  typedef struct packed {
    op_kind_t            kind;
    logic [ADDR_W-1:0]   addr;
    logic [CODE_W-1:0]   code;
  } op_t;

  typedef struct packed {
    logic [7:0] first_byte;
    logic [7:0] second_byte;
    logic       last;
  } res_t;

  typedef enum logic [1:0] {
    BK_IDLE  = 2'd0,
    BK_CLEAR = 2'd1,
    BK_EMIT  = 2'd2
  } bk_state_t;

endpackage

[hdl/ccsc_front.sv]
// Front end: accepts commands, clips and key-tests plots, and registers one operation.
module ccsc_front (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  output logic                         full,
  input  logic [1:0]                   command,
  input  logic signed [7:0]            origin_x,
  input  logic signed [7:0]            origin_y,
  input  logic [5:0]                   offset_x,
  input  logic [5:0]                   offset_y,
  input  logic [15:0]                  cell_code,
  input  logic [5:0]                   row_select,
  input  logic [ccsc_pkg::CODE_W-1:0]  key,
  output ccsc_pkg::op_t                op,
  output logic                         op_valid,
  input  logic                         op_full
);

  logic [8:0]                   pos_x;
  logic [8:0]                   pos_y;
  logic                         x_ok;
  logic                         y_ok;
  logic                         row_ok;
  logic [ccsc_pkg::COL_W-1:0]   x_cell;
  logic [ccsc_pkg::ROW_W-1:0]   y_cell;
  logic [ccsc_pkg::ROW_W-1:0]   r_cell;
  logic                         keep;
  ccsc_pkg::op_t                op_in;
  logic                         advance;
  logic                         valid;

  always_comb begin
    // Sign-extend the origin, then add the unsigned offset with no wrap.
    pos_x  = {origin_x[7], origin_x} + {3'b000, offset_x};
    pos_y  = {origin_y[7], origin_y} + {3'b000, offset_y};
    x_ok   = !pos_x[8] && (pos_x[7:0] < 8'(ccsc_pkg::FRAME_WIDTH));
    y_ok   = !pos_y[8] && (pos_y[7:0] < 8'(ccsc_pkg::FRAME_HEIGHT));
    row_ok = {1'b0, row_select} < 7'(ccsc_pkg::FRAME_HEIGHT);
    x_cell = pos_x[ccsc_pkg::COL_W-1:0];
    y_cell = pos_y[ccsc_pkg::ROW_W-1:0];
    r_cell = row_select[ccsc_pkg::ROW_W-1:0];

    op_in.kind = ccsc_pkg::OP_PLOT;
    op_in.addr = ccsc_pkg::ADDR_W'(y_cell) * ccsc_pkg::ADDR_W'(ccsc_pkg::FRAME_WIDTH)
               + ccsc_pkg::ADDR_W'(x_cell);
    op_in.code = cell_code;
    keep       = 1'b0;
    unique case (ccsc_pkg::cmd_t'(command))
      ccsc_pkg::CMD_CLEAR: begin
        op_in.kind = ccsc_pkg::OP_CLEAR;
        op_in.code = key;
        keep       = 1'b1;
      end
      ccsc_pkg::CMD_PLOT: begin
        keep = x_ok && y_ok && (cell_code != key);
      end
      ccsc_pkg::CMD_EMIT: begin
        op_in.kind = ccsc_pkg::OP_EMIT;
        op_in.addr = ccsc_pkg::ADDR_W'(r_cell) * ccsc_pkg::ADDR_W'(ccsc_pkg::FRAME_WIDTH);
        keep       = row_ok;
      end
      ccsc_pkg::CMD_NOP: begin
        keep = 1'b0;
      end
    endcase
  end

  // The held operation moves on whenever the queue has room.
  assign advance  = !valid || !op_full;
  assign full     = !advance;
  assign op_valid = valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (advance) begin
      valid <= push && keep;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      op <= op_in;
    end
  end

endmodule

[hdl/ccsc_queue.sv]
// Short operation queue between the front end and the frame sequencer.
module ccsc_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  ccsc_pkg::op_t  din,
  output logic           full,
  input  logic           pop,
  output ccsc_pkg::op_t  dout,
  output logic           empty
);

  ccsc_pkg::op_t                  slots [ccsc_pkg::Q_DEPTH];
  logic [ccsc_pkg::Q_PTR_W-1:0]   wr_ptr;
  logic [ccsc_pkg::Q_PTR_W-1:0]   rd_ptr;
  logic [ccsc_pkg::Q_CNT_W-1:0]   count;
  logic                           do_push;
  logic                           do_pop;

  assign full    = (count == ccsc_pkg::Q_CNT_W'(ccsc_pkg::Q_DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= din;
    end
  end

endmodule

[hdl/ccsc_back.sv]
// Back end: frame memory, clear and emit walks, and the result queue.
module ccsc_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_empty,
  input  ccsc_pkg::op_t  q_op,
  output logic           q_pop,
  output ccsc_pkg::res_t res,
  output logic           empty,
  input  logic           pop
);

  logic [ccsc_pkg::CODE_W-1:0]   mem [ccsc_pkg::CELL_COUNT];

  ccsc_pkg::bk_state_t           state;
  ccsc_pkg::bk_state_t           state_next;
  logic [ccsc_pkg::ADDR_W-1:0]   walk_addr;
  logic [ccsc_pkg::ADDR_W-1:0]   walk_addr_next;
  logic [ccsc_pkg::COL_W-1:0]    col;
  logic [ccsc_pkg::COL_W-1:0]    col_next;
  logic [ccsc_pkg::CODE_W-1:0]   fill;
  logic [ccsc_pkg::CODE_W-1:0]   fill_next;

  logic                          mem_we;
  logic [ccsc_pkg::ADDR_W-1:0]   mem_wa;
  logic [ccsc_pkg::CODE_W-1:0]   mem_wd;
  logic                          rd_en;
  logic                          rd_end;
  logic                          rd_valid;
  logic                          rd_last;
  logic [ccsc_pkg::CODE_W-1:0]   rd_data;

  ccsc_pkg::res_t                 out_q [ccsc_pkg::OUT_DEPTH];
  ccsc_pkg::res_t                 out_in;
  logic [ccsc_pkg::OUT_PTR_W-1:0] out_wr;
  logic [ccsc_pkg::OUT_PTR_W-1:0] out_rd;
  logic [ccsc_pkg::OUT_CNT_W-1:0] out_count;
  logic                           room;
  logic                           do_pop;
  logic                           col_end;
  logic                           clear_end;

  // Leave a slot for the read already in flight.
  assign room = (out_count + ccsc_pkg::OUT_CNT_W'(rd_valid))
              < ccsc_pkg::OUT_CNT_W'(ccsc_pkg::OUT_DEPTH);
  assign col_end   = (col == ccsc_pkg::COL_W'(ccsc_pkg::FRAME_WIDTH - 1));
  assign clear_end = (walk_addr == ccsc_pkg::ADDR_W'(ccsc_pkg::CELL_COUNT - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ccsc_pkg::BK_IDLE;
      walk_addr <= '0;
      col       <= '0;
    end else begin
      state     <= state_next;
      walk_addr <= walk_addr_next;
      col       <= col_next;
    end
  end

  always_ff @(posedge clk) begin
    fill <= fill_next;
  end

  always_comb begin
    state_next     = state;
    walk_addr_next = walk_addr;
    col_next       = col;
    fill_next      = fill;
    q_pop          = 1'b0;
    mem_we         = 1'b0;
    mem_wa         = q_op.addr;
    mem_wd         = q_op.code;
    rd_en          = 1'b0;
    rd_end         = 1'b0;
    unique case (state)
      ccsc_pkg::BK_IDLE: begin
        if (!q_empty) begin
          q_pop = 1'b1;
          unique case (q_op.kind)
            ccsc_pkg::OP_PLOT: begin
              mem_we = 1'b1;
            end
            ccsc_pkg::OP_CLEAR: begin
              fill_next      = q_op.code;
              walk_addr_next = '0;
              state_next     = ccsc_pkg::BK_CLEAR;
            end
            ccsc_pkg::OP_EMIT: begin
              walk_addr_next = q_op.addr;
              col_next       = '0;
              state_next     = ccsc_pkg::BK_EMIT;
            end
            default: begin
              q_pop = 1'b1;
            end
          endcase
        end
      end
      ccsc_pkg::BK_CLEAR: begin
        mem_we = 1'b1;
        mem_wa = walk_addr;
        mem_wd = fill;
        if (clear_end) begin
          walk_addr_next = '0;
          state_next     = ccsc_pkg::BK_IDLE;
        end else begin
          walk_addr_next = walk_addr + 1'b1;
        end
      end
      ccsc_pkg::BK_EMIT: begin
        if (room) begin
          rd_en          = 1'b1;
          rd_end         = col_end;
          walk_addr_next = walk_addr + 1'b1;
          if (col_end) begin
            col_next   = '0;
            state_next = ccsc_pkg::BK_IDLE;
          end else begin
            col_next = col + 1'b1;
          end
        end
      end
      default: begin
        state_next = ccsc_pkg::BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[walk_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= rd_en;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_last <= rd_end;
    end
  end

  // Wide codes give both bytes; narrow codes give the low byte and a space.
  always_comb begin
    out_in.last = rd_last;
    if (rd_data[15]) begin
      out_in.first_byte  = rd_data[15:8];
      out_in.second_byte = rd_data[7:0];
    end else begin
      out_in.first_byte  = rd_data[7:0];
      out_in.second_byte = ccsc_pkg::SPACE_BYTE;
    end
  end

  assign empty  = (out_count == '0);
  assign do_pop = pop && !empty;
  assign res    = out_q[out_rd];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_wr    <= '0;
      out_rd    <= '0;
      out_count <= '0;
    end else begin
      if (rd_valid) begin
        out_wr <= out_wr + 1'b1;
      end
      if (do_pop) begin
        out_rd <= out_rd + 1'b1;
      end
      if (rd_valid && !do_pop) begin
        out_count <= out_count + 1'b1;
      end else if (do_pop && !rd_valid) begin
        out_count <= out_count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_valid) begin
      out_q[out_wr] <= out_in;
    end
  end

endmodule

[hdl/char_cell_sprite_compositor.sv]
// Top level of the character-cell frame store with sprite compositing.
// Commands enter through a push/full queue port and are classified in one registered front
// stage (clip test, key test, cell address), then wait in a four-entry operation queue for
// the frame sequencer. Plot commands that land in the frame use the single frame memory
// write port, one per cycle while the sequencer is idle. A clear walks every cell
// (FRAME_WIDTH * FRAME_HEIGHT) on the write port; an emit reads one cell per cycle on the
// read port, FRAME_WIDTH cells per row, registers the read data and slows down to the rate
// at which results are popped from the four-entry result queue. Dropped plots, out-of-range
// rows and the unused command are absorbed by the front stage. The frame holds no defined
// value after reset until a clear or plot writes it. The transparent key answers at
// addresses 0 to 3 of the configuration port (paddr[2] low) and resets to 0xA1A1.
module char_cell_sprite_compositor (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           push,
  output logic                           full,
  input  logic [1:0]                     command,
  input  logic signed [7:0]              origin_x,
  input  logic signed [7:0]              origin_y,
  input  logic [5:0]                     offset_x,
  input  logic [5:0]                     offset_y,
  input  logic [15:0]                    cell_code,
  input  logic [5:0]                     row_select,
  output logic                           empty,
  input  logic                           pop,
  output logic [7:0]                     first_byte,
  output logic [7:0]                     second_byte,
  output logic                           last,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [ccsc_pkg::PADDR_W-1:0]   paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);

  logic [ccsc_pkg::CODE_W-1:0] key;
  logic                        key_sel;
  ccsc_pkg::op_t               fr_op;
  logic                        fr_valid;
  logic                        q_full;
  ccsc_pkg::op_t               q_op;
  logic                        q_empty;
  logic                        q_pop;
  ccsc_pkg::res_t              res;

  assign pready  = 1'b1;
  assign key_sel = (paddr[ccsc_pkg::PADDR_W-1] == ccsc_pkg::REG_KEY);
  assign prdata  = key_sel ? {16'h0000, key} : 32'h0000_0000;

  always_ff @(posedge clk) begin
    if (rst) begin
      key <= ccsc_pkg::KEY_RESET;
    end else if (psel && penable && pwrite && pready && key_sel) begin
      key <= pwdata[ccsc_pkg::CODE_W-1:0];
    end
  end

  ccsc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .command    (command),
    .origin_x   (origin_x),
    .origin_y   (origin_y),
    .offset_x   (offset_x),
    .offset_y   (offset_y),
    .cell_code  (cell_code),
    .row_select (row_select),
    .key        (key),
    .op         (fr_op),
    .op_valid   (fr_valid),
    .op_full    (q_full)
  );

  ccsc_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (fr_valid),
    .din   (fr_op),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (q_op),
    .empty (q_empty)
  );

  ccsc_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .q_op    (q_op),
    .q_pop   (q_pop),
    .res     (res),
    .empty   (empty),
    .pop     (pop)
  );

  assign first_byte  = res.first_byte;
  assign second_byte = res.second_byte;
  assign last        = res.last;

endmodule

[hdl/ccsc_checker.sv]
// Port-level checker for the compositor, bound to the top level.
`include "char_cell_sprite_compositor_assert.svh"

module ccsc_port_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           empty,
  input logic                           pop,
  input logic [7:0]                     first_byte,
  input logic [7:0]                     second_byte,
  input logic                           last,
  input logic                           psel,
  input logic                           penable,
  input logic                           pwrite,
  input logic [ccsc_pkg::PADDR_W-1:0]   paddr,
  input logic [31:0]                    pwdata,
  input logic [31:0]                    prdata
);

  // No result survives a reset.
  `CCSC_ASSERT_NEXT(a_reset_empty, clk, 1'b0, rst, empty, "result queue not empty after reset")

  // A waiting result holds until its transfer.
  `CCSC_ASSERT_NEXT(a_result_hold, clk, rst, !empty && !pop, !empty && $stable(first_byte) && $stable(second_byte) && $stable(last), "waiting result changed")

  // A key write reads back on the next cycle.
  `CCSC_ASSERT_NEXT(a_key_readback, clk, rst, psel && penable && pwrite && !paddr[ccsc_pkg::PADDR_W-1], paddr[ccsc_pkg::PADDR_W-1] || (prdata[15:0] == $past(pwdata[15:0])), "key readback mismatch")

  // The key is 16 bits wide; upper read data stays zero.
  `CCSC_ASSERT_NOW(a_prdata_upper, clk, rst, 1'b1, prdata[31:16] == 16'h0000, "upper read data not zero")

endmodule

bind char_cell_sprite_compositor ccsc_port_checker u_ccsc_checker (.*);
